/* rtl/mhpq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and constants for the max-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int DEPTH   = 64;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int KEY_W   = 32;
    localparam int MODE_W  = 2;
    localparam int POS_W   = 6;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 7;
    localparam int CMP_W   = (ADDR_W + 2 > POS_W) ? ADDR_W + 2 : POS_W + 1;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 80;

    localparam logic [KEY_W-1:0] EMPTY_KEY = '1;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_CHANGE = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_BAD_POS = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RM_LD,
        S_CH_LD,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_WR_KEY,
        S_RESP
    } state_t;

    typedef enum logic [1:0] {
        RM_ZERO,
        RM_TOP,
        RM_EMPTY
    } rm_sel_t;

    typedef enum logic [2:0] {
        IX_HOLD,
        IX_CNT,
        IX_ZERO,
        IX_POS,
        IX_PARENT,
        IX_BIG
    } idx_sel_t;

    typedef enum logic [1:0] {
        KS_HOLD,
        KS_VAL,
        KS_RDATA
    } key_sel_t;

    typedef enum logic [1:0] {
        CN_HOLD,
        CN_INC,
        CN_DEC
    } cnt_op_t;

    typedef enum logic [2:0] {
        RS_PARENT,
        RS_LEFT,
        RS_RIGHT,
        RS_LAST,
        RS_POS
    } rd_sel_t;

    typedef enum logic [1:0] {
        WS_NONE,
        WS_RDATA,
        WS_BIG,
        WS_KEY
    } wr_sel_t;

    typedef struct packed {
        logic     capture;
        logic     start;
        status_t  status;
        rm_sel_t  rm_sel;
        idx_sel_t idx_sel;
        key_sel_t key_sel;
        cnt_op_t  cnt_op;
        logic     lat_left;
        rd_sel_t  rd_sel;
        wr_sel_t  wr_sel;
        logic     load_out;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  full;
        logic  empty;
        logic  pos_bad;
        logic  idx_nz;
        logic  key_gt_rd;
        logic  rd_gt_key;
        logic  has_l;
        logic  dn_go;
        logic  out_free;
    } sts_t;

endpackage

/* rtl/mhpq_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/mhpq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Operation sequencer: dispatch, sift-up and sift-down walks, result hand-off.
// ----------------------------------------------------------------------------
module mhpq_ctrl
    import mhpq_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_DISPATCH;
            end
            S_DISPATCH: begin
                unique case (sts.mode)
                    MODE_INSERT: state_next = sts.full ? S_RESP : S_UP_RD;
                    MODE_REMOVE: state_next = sts.empty ? S_RESP : S_RM_LD;
                    MODE_CHANGE: state_next = sts.pos_bad ? S_RESP : S_CH_LD;
                    default:     state_next = S_RESP;
                endcase
            end
            S_RM_LD: state_next = S_DN_RDL;
            S_CH_LD: begin
                if (sts.key_gt_rd) begin
                    state_next = S_UP_RD;
                end else if (sts.rd_gt_key) begin
                    state_next = S_DN_RDL;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_UP_RD:  state_next = sts.idx_nz ? S_UP_CMP : S_WR_KEY;
            S_UP_CMP: state_next = sts.key_gt_rd ? S_UP_RD : S_WR_KEY;
            S_DN_RDL: state_next = sts.has_l ? S_DN_RDR : S_WR_KEY;
            S_DN_RDR: state_next = S_DN_CMP;
            S_DN_CMP: state_next = sts.dn_go ? S_DN_RDL : S_WR_KEY;
            S_WR_KEY: state_next = S_RESP;
            S_RESP: begin
                if (sts.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            S_DISPATCH: begin
                cmd.start = 1'b1;
                unique case (sts.mode)
                    MODE_INSERT: begin
                        if (sts.full) begin
                            cmd.status = STAT_FULL;
                        end else begin
                            cmd.idx_sel = IX_CNT;
                            cmd.key_sel = KS_VAL;
                            cmd.cnt_op  = CN_INC;
                        end
                    end
                    MODE_REMOVE: begin
                        if (sts.empty) begin
                            cmd.status = STAT_EMPTY;
                            cmd.rm_sel = RM_EMPTY;
                        end else begin
                            cmd.rm_sel  = RM_TOP;
                            cmd.idx_sel = IX_ZERO;
                            cmd.cnt_op  = CN_DEC;
                            cmd.rd_sel  = RS_LAST;
                        end
                    end
                    MODE_CHANGE: begin
                        if (sts.pos_bad) begin
                            cmd.status = STAT_BAD_POS;
                        end else begin
                            cmd.idx_sel = IX_POS;
                            cmd.key_sel = KS_VAL;
                            cmd.rd_sel  = RS_POS;
                        end
                    end
                    default: cmd.status = STAT_OK;
                endcase
            end
            S_RM_LD:  cmd.key_sel = KS_RDATA;
            S_CH_LD:  cmd.key_sel = KS_HOLD;
            S_UP_RD:  cmd.rd_sel  = RS_PARENT;
            S_UP_CMP: begin
                if (sts.key_gt_rd) begin
                    cmd.wr_sel  = WS_RDATA;
                    cmd.idx_sel = IX_PARENT;
                end
            end
            S_DN_RDL: cmd.rd_sel = RS_LEFT;
            S_DN_RDR: begin
                cmd.lat_left = 1'b1;
                cmd.rd_sel   = RS_RIGHT;
            end
            S_DN_CMP: begin
                if (sts.dn_go) begin
                    cmd.wr_sel  = WS_BIG;
                    cmd.idx_sel = IX_BIG;
                end
            end
            S_WR_KEY: cmd.wr_sel   = WS_KEY;
            S_RESP:   cmd.load_out = sts.out_free;
            default:  cmd.capture  = 1'b0;
        endcase
    end

endmodule

/* rtl/mhpq_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_dp
// Heap datapath: key store, walk index, moving key, count, root copy and
// the result register.
// ----------------------------------------------------------------------------
module mhpq_dp
    import mhpq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  cmd_t                cmd,
    output sts_t                sts,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    mode_t              mode_reg,    mode_next;
    logic [KEY_W-1:0]   val_reg,     val_next;
    logic [POS_W-1:0]   pos_reg,     pos_next;
    logic [ADDR_W-1:0]  idx_reg,     idx_next;
    logic [KEY_W-1:0]   key_reg,     key_next;
    logic [CNT_W-1:0]   cnt_reg,     cnt_next;
    logic [KEY_W-1:0]   top_reg,     top_next;
    logic [KEY_W-1:0]   lval_reg,    lval_next;
    status_t            status_reg,  status_next;
    logic [KEY_W-1:0]   removed_reg, removed_next;
    logic               mvalid_reg,  mvalid_next;
    logic [M_DATA_W-1:0] mdata_reg,  mdata_next;

    logic [KEY_W-1:0]  rdata;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] waddr;
    logic [KEY_W-1:0]  wdata;
    logic              we;

    logic [CMP_W-1:0]  idx_w;
    logic [CMP_W-1:0]  cnt_w;
    logic [CMP_W-1:0]  pos_w;
    logic [CMP_W-1:0]  left_w;
    logic [CMP_W-1:0]  right_w;
    logic [ADDR_W-1:0] parent;
    logic [ADDR_W-1:0] last;
    logic              right_big;
    logic [KEY_W-1:0]  big_val;
    logic [ADDR_W-1:0] big_idx;
    logic [KEY_W-1:0]  top_out;
    logic              has_r;

    assign idx_w   = CMP_W'(idx_reg);
    assign cnt_w   = CMP_W'(cnt_reg);
    assign pos_w   = CMP_W'(pos_reg);
    assign left_w  = (idx_w << 1) + CMP_W'(1);
    assign right_w = (idx_w << 1) + CMP_W'(2);
    assign parent  = (idx_reg - ADDR_W'(1)) >> 1;
    assign last    = ADDR_W'(cnt_reg - CNT_W'(1));
    assign has_r   = right_w < cnt_w;

    // right child wins ties
    assign right_big = has_r && !($signed(lval_reg) > $signed(rdata));
    assign big_val   = right_big ? rdata : lval_reg;
    assign big_idx   = right_big ? right_w[ADDR_W-1:0] : left_w[ADDR_W-1:0];

    assign top_out = (cnt_reg != '0) ? top_reg : EMPTY_KEY;

    always_comb begin
        sts.mode      = mode_reg;
        sts.full      = cnt_w >= CMP_W'(DEPTH);
        sts.empty     = cnt_reg == '0;
        sts.pos_bad   = (pos_w >= cnt_w) || (pos_w >= CMP_W'(DEPTH));
        sts.idx_nz    = idx_reg != '0;
        sts.key_gt_rd = $signed(key_reg) > $signed(rdata);
        sts.rd_gt_key = $signed(rdata) > $signed(key_reg);
        sts.has_l     = left_w < cnt_w;
        sts.dn_go     = $signed(big_val) > $signed(key_reg);
        sts.out_free  = !mvalid_reg || m_tready;
    end

    always_comb begin
        case (cmd.rd_sel)
            RS_PARENT: raddr = parent;
            RS_LEFT:   raddr = left_w[ADDR_W-1:0];
            RS_RIGHT:  raddr = right_w[ADDR_W-1:0];
            RS_LAST:   raddr = last;
            RS_POS:    raddr = pos_w[ADDR_W-1:0];
            default:   raddr = idx_reg;
        endcase
    end

    always_comb begin
        waddr = idx_reg;
        we    = 1'b1;
        case (cmd.wr_sel)
            WS_RDATA: wdata = rdata;
            WS_BIG:   wdata = big_val;
            WS_KEY:   wdata = key_reg;
            default: begin
                wdata = key_reg;
                we    = 1'b0;
            end
        endcase
    end

    mhpq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        mode_next    = mode_reg;
        val_next     = val_reg;
        pos_next     = pos_reg;
        if (cmd.capture) begin
            mode_next = mode_t'(s_tdata[MODE_W-1:0]);
            val_next  = s_tdata[MODE_W +: KEY_W];
            pos_next  = s_tdata[MODE_W+KEY_W +: POS_W];
        end

        case (cmd.idx_sel)
            IX_CNT:    idx_next = ADDR_W'(cnt_reg);
            IX_ZERO:   idx_next = '0;
            IX_POS:    idx_next = pos_w[ADDR_W-1:0];
            IX_PARENT: idx_next = parent;
            IX_BIG:    idx_next = big_idx;
            default:   idx_next = idx_reg;
        endcase

        case (cmd.key_sel)
            KS_VAL:   key_next = val_reg;
            KS_RDATA: key_next = rdata;
            default:  key_next = key_reg;
        endcase

        case (cmd.cnt_op)
            CN_INC:  cnt_next = cnt_reg + CNT_W'(1);
            CN_DEC:  cnt_next = cnt_reg - CNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase

        top_next  = (we && waddr == '0) ? wdata : top_reg;
        lval_next = cmd.lat_left ? rdata : lval_reg;

        status_next  = status_reg;
        removed_next = removed_reg;
        if (cmd.start) begin
            status_next = cmd.status;
            case (cmd.rm_sel)
                RM_TOP:   removed_next = top_reg;
                RM_EMPTY: removed_next = EMPTY_KEY;
                default:  removed_next = '0;
            endcase
        end

        mvalid_next = mvalid_reg && !m_tready;
        mdata_next  = mdata_reg;
        if (cmd.load_out) begin
            mvalid_next = 1'b1;
            mdata_next  = M_DATA_W'({OCC_W'(cnt_reg), cnt_reg != '0, top_out,
                                     removed_reg, status_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            cnt_reg    <= cnt_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg    <= mode_next;
        val_reg     <= val_next;
        pos_reg     <= pos_next;
        idx_reg     <= idx_next;
        key_reg     <= key_next;
        top_reg     <= top_next;
        lval_reg    <= lval_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
        mdata_reg   <= mdata_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

endmodule

/* rtl/max_heap_priority_queue_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_heap_priority_queue_unit
// Binary max-heap of signed 32-bit keys: insert, remove maximum, change key.
//
//   port group  dir  contents (tdata from bit 0 up)
//   s_*         in   mode[1:0], new_value[33:2], position[39:34]
//   m_*         out  status[1:0], removed_value[33:2], top_value[65:34],
//                    top_valid[66], occupancy[73:67]
//
// One operation at a time.
// Rejected or unused operations go straight to the result. Insert climbs
// one level per parent read and compare. Removal sinks one level per left
// child read, right child read and compare. Change climbs as insert, sinks
// as removal, or ends at once for an equal key. The single read port of the
// key store sets the per-level cost.
// Reset empties the heap; the store itself is not cleared.
// A result still waiting in the output register holds the unit in its last
// cycle, so s_tready stays low until m_tready frees it.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_unit
    import mhpq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // mode, new_value, position
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // status, removed_value, top_value,
                                           // top_valid, occupancy
);

    cmd_t cmd;
    sts_t sts;

    mhpq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mhpq_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for max_heap_priority_queue_unit.
//
// Sends heap operations (insert, remove maximum, change key, unused mode) over
// the s_ stream and predicts each result with a behavioral max-heap kept
// alongside. A short directed table covers empty, bad position, equal keys
// and key extremes. Random phases follow, biased toward filling, draining
// or mixing. Results on the m_ stream are checked field by field in order.
// Both sides idle at random. The receiver once holds off for a long stretch;
// the sender waits for all results after the first and some later phases.
// ----------------------------------------------------------------------------
module testbench;
    import mhpq_pkg::*;

    localparam int N_DIRECTED   = 25;
    localparam int N_RANDOM     = 1625;
    localparam int LIMIT_CYCLES = 400000;
    localparam int TAIL_CYCLES  = 40;

    typedef struct {
        status_t     status;
        logic [31:0] removed;
        logic [31:0] top;
        logic        valid;
        logic [6:0]  occ;
    } heap_result_t;

    typedef struct {
        mode_t        mode;
        logic [31:0]  key;
        logic [5:0]   pos;
        bit           lit;
        heap_result_t want;
    } op_row_t;

    typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    max_heap_priority_queue_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // predicted heap
    logic signed [31:0] heap_keys [DEPTH];
    int                 heap_count;

    heap_result_t pending_results [$];
    heap_result_t row_want;
    bit           row_lit;
    int           sent_count;
    int           recv_count;
    int           errors;
    int           cycle_count;
    op_row_t      directed_ops [N_DIRECTED];

    function automatic void swap_keys(int a, int b);
        logic signed [31:0] t;
        t            = heap_keys[a];
        heap_keys[a] = heap_keys[b];
        heap_keys[b] = t;
    endfunction

    function automatic void climb(int i);
        int p;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!(heap_keys[i] > heap_keys[p]))
                break;
            swap_keys(i, p);
            i = p;
        end
    endfunction

    // right child wins a tie; swap only when strictly smaller
    function automatic void sink(int i);
        int l;
        int r;
        int big;
        while (1) begin
            l = 2 * i + 1;
            r = l + 1;
            if (l >= heap_count)
                break;
            if (r < heap_count)
                big = (heap_keys[l] > heap_keys[r]) ? l : r;
            else
                big = l;
            if (!(heap_keys[big] > heap_keys[i]))
                break;
            swap_keys(i, big);
            i = big;
        end
    endfunction

    function automatic heap_result_t predict_heap_op(mode_t m, logic [31:0] key,
                                                     logic [5:0] pos);
        heap_result_t       r;
        logic signed [31:0] old_key;
        r.status  = STAT_OK;
        r.removed = '0;
        case (m)
            MODE_INSERT: begin
                if (heap_count >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    heap_keys[heap_count] = key;
                    heap_count++;
                    climb(heap_count - 1);
                end
            end
            MODE_REMOVE: begin
                if (heap_count == 0) begin
                    r.status  = STAT_EMPTY;
                    r.removed = EMPTY_KEY;
                end else begin
                    r.removed    = heap_keys[0];
                    heap_keys[0] = heap_keys[heap_count - 1];
                    heap_count--;
                    sink(0);
                end
            end
            MODE_CHANGE: begin
                if (int'(pos) >= heap_count) begin
                    r.status = STAT_BAD_POS;
                end else begin
                    old_key        = heap_keys[pos];
                    heap_keys[pos] = key;
                    if ($signed(key) > old_key)
                        climb(pos);
                    else if (old_key > $signed(key))
                        sink(pos);
                end
            end
            default: ;
        endcase
        r.top   = (heap_count > 0) ? heap_keys[0] : EMPTY_KEY;
        r.valid = (heap_count > 0);
        r.occ   = heap_count[6:0];
        return r;
    endfunction

    task automatic check_result(heap_result_t want, logic [M_DATA_W-1:0] data);
        heap_result_t got;
        got.status  = status_t'(data[1:0]);
        got.removed = data[33:2];
        got.top     = data[65:34];
        got.valid   = data[66];
        got.occ     = data[73:67];
        if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            errors++;
        end
        if (got.removed !== want.removed) begin
            $display("%0t: removed_value expected %0d got %0d", $time,
                     $signed(want.removed), $signed(got.removed));
            errors++;
        end
        if (got.top !== want.top) begin
            $display("%0t: top_value expected %0d got %0d", $time,
                     $signed(want.top), $signed(got.top));
            errors++;
        end
        if (got.valid !== want.valid) begin
            $display("%0t: top_valid expected %0d got %0d", $time, want.valid, got.valid);
            errors++;
        end
        if (got.occ !== want.occ) begin
            $display("%0t: occupancy expected %0d got %0d", $time, want.occ, got.occ);
            errors++;
        end
        if (data[M_DATA_W-1:74] !== '0) begin
            $display("%0t: tdata pad expected 0 got %h", $time, data[M_DATA_W-1:74]);
            errors++;
        end
    endtask

    // predict on every input transfer, check every output transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                row_want = predict_heap_op(mode_t'(s_tdata[1:0]), s_tdata[33:2],
                                           s_tdata[39:34]);
                pending_results.push_back(row_lit ? directed_ops[sent_count - 1].want
                                                  : row_want);
            end
            if (m_tvalid && m_tready) begin
                recv_count++;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result transfer, expected none got %h",
                             $time, m_tdata);
                    errors++;
                end else begin
                    check_result(pending_results.pop_front(), m_tdata);
                end
            end
        end
    end

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= LIMIT_CYCLES) begin
                $display("max_heap_priority_queue_unit verification failed");
                $finish;
            end
        end
    end

    // receiver: random stalls, a quiet window, one long hold-off
    initial begin
        int  hold_left;
        bit  held_once;
        hold_left = 0;
        held_once = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (!aresetn) begin
                m_tready = 1'b0;
            end else if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else if (!held_once && recv_count >= 250) begin
                held_once = 1;
                hold_left = 400;
                m_tready  = 1'b0;
            end else begin
                m_tready = (recv_count >= 900 && recv_count < 1100) ||
                           ($urandom_range(99) >= 13);
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic push_op(mode_t m, logic [31:0] key, logic [5:0] pos, bit lit);
        if (!(sent_count >= 900 && sent_count < 1100) && $urandom_range(99) < 13) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {pos, key, m};
        row_lit  = lit;
        sent_count++;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_key();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom_range(0, 7);
            3:       return -$urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [5:0] pick_pos();
        if (heap_count > 0 && $urandom_range(99) < 85)
            return 6'($urandom_range(0, heap_count - 1));
        return 6'($urandom_range(0, 63));
    endfunction

    function automatic mode_t pick_mode(phase_t ph);
        int r;
        int ins_lim;
        int rem_lim;
        r = $urandom_range(99);
        case (ph)
            PH_FILL:  begin ins_lim = 75; rem_lim = 85; end
            PH_DRAIN: begin ins_lim = 15; rem_lim = 80; end
            default:  begin ins_lim = 40; rem_lim = 75; end
        endcase
        if (r < ins_lim)
            return MODE_INSERT;
        if (r < rem_lim)
            return MODE_REMOVE;
        if (r < 97)
            return MODE_CHANGE;
        return MODE_UNUSED;
    endfunction

    initial begin
        phase_t ph;
        int     len;
        bit     first;
        directed_ops = '{
            '{MODE_REMOVE, 32'h0,        6'd0,  1'b1,
              '{STAT_EMPTY,   EMPTY_KEY, EMPTY_KEY,    1'b0, 7'd0}},
            '{MODE_CHANGE, 32'h12345678, 6'd0,  1'b1,
              '{STAT_BAD_POS, 32'h0,     EMPTY_KEY,    1'b0, 7'd0}},
            '{MODE_UNUSED, 32'hFFFFFFFF, 6'd63, 1'b1,
              '{STAT_OK,      32'h0,     EMPTY_KEY,    1'b0, 7'd0}},
            '{MODE_INSERT, 32'h7FFFFFFF, 6'd0,  1'b1,
              '{STAT_OK,      32'h0,     32'h7FFFFFFF, 1'b1, 7'd1}},
            '{MODE_INSERT, 32'h80000000, 6'd63, 1'b1,
              '{STAT_OK,      32'h0,     32'h7FFFFFFF, 1'b1, 7'd2}},
            '{MODE_INSERT, 32'd5,        6'd0,  1'b0, '{STAT_OK, 0, 0, 0, 0}},
            '{MODE_INSERT, 32'd5,        6'd0,  1'b0, '{STAT_OK, 0, 0, 0, 0}},
            '{MODE_INSERT, 32'hFFFFFFFF, 6'd0,  1'b0, '{STAT_OK, 0, 0, 0, 0}},
            '{MODE_INSERT, 32'h0,        6'd0,  1'b0, '{STAT_OK, 0, 0, 0, 0}},
            '{MODE_CHANGE, 32'h0,        6'd63, 1'b1,
              '{STAT_BAD_POS, 32'h0,     32'h7FFFFFFF, 1'b1, 7'd6}},
            '{MODE_CHANGE, 32'h7FFFFFFF, 6'd0,  1'b0, '{STAT_OK, 0, 0, 0, 0}},
            '{MODE_CHANGE, -32'sd100,    6'd0,  1'b0, '{STAT_OK, 0, 0, 0, 0}},
            '{MODE_CHANGE, 32'h7FFFFFFF, 6'd5,  1'b0, '{STAT_OK, 0, 0, 0, 0}},
            '{MODE_UNUSED, 32'h0,        6'd0,  1'b0, '{STAT_OK, 0, 0, 0, 0}},
            '{MODE_INSERT, 32'd5,        6'd0,  1'b0, '{STAT_OK, 0, 0, 0, 0}},
            '{MODE_REMOVE, 32'h0,        6'd0,  1'b0, '{STAT_OK, 0, 0, 0, 0}},
            '{MODE_REMOVE, 32'h0,        6'd0,  1'b0, '{STAT_OK, 0, 0, 0, 0}},
            '{MODE_REMOVE, 32'h0,        6'd0,  1'b0, '{STAT_OK, 0, 0, 0, 0}},
            '{MODE_REMOVE, 32'h0,        6'd0,  1'b0, '{STAT_OK, 0, 0, 0, 0}},
            '{MODE_REMOVE, 32'h0,        6'd0,  1'b0, '{STAT_OK, 0, 0, 0, 0}},
            '{MODE_REMOVE, 32'h0,        6'd0,  1'b0, '{STAT_OK, 0, 0, 0, 0}},
            '{MODE_REMOVE, 32'h0,        6'd0,  1'b0, '{STAT_OK, 0, 0, 0, 0}},
            '{MODE_REMOVE, 32'h0,        6'd0,  1'b1,
              '{STAT_EMPTY,   EMPTY_KEY, EMPTY_KEY,    1'b0, 7'd0}},
            '{MODE_INSERT, 32'h80000000, 6'd0,  1'b1,
              '{STAT_OK,      32'h0,     32'h80000000, 1'b1, 7'd1}},
            '{MODE_REMOVE, 32'h0,        6'd0,  1'b1,
              '{STAT_OK,      32'h80000000, EMPTY_KEY, 1'b0, 7'd0}}
        };
        heap_count = 0;
        sent_count = 0;
        recv_count = 0;
        errors     = 0;
        row_lit    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        aresetn    = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            push_op(directed_ops[i].mode, directed_ops[i].key, directed_ops[i].pos,
                    directed_ops[i].lit);

        // first phase fills the heap past full, then the sender waits for it to settle
        first = 1;
        while (sent_count < N_DIRECTED + N_RANDOM) begin
            ph  = first ? PH_FILL : phase_t'($urandom_range(2));
            len = first ? 150 : $urandom_range(30, 130);
            for (int k = 0; k < len && sent_count < N_DIRECTED + N_RANDOM; k++)
                push_op(pick_mode(ph), pick_key(), pick_pos(), 1'b0);
            if (first || $urandom_range(3) == 0) begin
                s_tvalid = 1'b0;
                while (pending_results.size() != 0)
                    @(negedge aclk);
            end
            first = 0;
        end
        s_tvalid = 1'b0;

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("max_heap_priority_queue_unit verification clean");
        else
            $display("max_heap_priority_queue_unit verification failed");
        $finish;
    end

endmodule
